// ===== rtl/mlp_backprop_train_step_top_macros.svh =====
// Assertion macros for the 2-2-2 MLP training step.
// Taken in by the files that assert; needs clk and rst in scope.
`ifndef MLP_BACKPROP_TRAIN_STEP_TOP_MACROS_SVH
`define MLP_BACKPROP_TRAIN_STEP_TOP_MACROS_SVH

// same-cycle implication
`define MLPBP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLPBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mlpbp_pkg.sv =====
// Package for the 2-2-2 MLP training step: fixed-point constants and the
// sigmoid lookup table, built at elaboration. No dependencies.
package mlpbp_pkg;

  localparam int FRAC_BITS = 12;
  localparam int SIG_DEPTH = 256;
  localparam int IDX_W     = $clog2(SIG_DEPTH);
  localparam int NET_W     = 16;
  localparam int ACT_W     = FRAC_BITS + 1;
  localparam int LR_W      = 13;
  localparam int ERR_W     = 12;
  localparam int TGT_W     = 13;

  localparam logic [ACT_W-1:0]        ONE_Q    = ACT_W'(1 << FRAC_BITS);
  localparam logic [LR_W-1:0]         LR_RESET = LR_W'(410);
  localparam logic signed [NET_W-1:0] W_ONE    = NET_W'(1 << FRAC_BITS);
  localparam logic signed [NET_W-1:0] W_MONE   = -NET_W'(1 << FRAC_BITS);

  localparam longint unsigned Q31_ONE  = 64'd2147483648;
  localparam longint unsigned EXP_BASE = 64'd2147450880;

  typedef logic [ACT_W-1:0] sig_table_t [SIG_DEPTH];

  function automatic longint unsigned mul_q31(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + (Q31_ONE >> 1)) >> 31;
  endfunction

  function automatic longint unsigned exp_neg_q31(input longint unsigned arg);
    longint unsigned r;
    longint unsigned b;
    longint unsigned a;
    r = Q31_ONE;
    b = EXP_BASE;
    a = arg;
    while (a != 0) begin
      if (a[0]) r = mul_q31(r, b);
      b = mul_q31(b, b);
      a = a >> 1;
    end
    return r;
  endfunction

  // restoring shift-subtract quotient
  function automatic longint unsigned udiv_u64(input longint unsigned num,
                                               input longint unsigned dvs);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t      t;
    longint          c;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned s;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      c   = longint'(((64'(2 * i + 1)) * 64'd32768) >> IDX_W) - 64'sd32768;
      mag = longint'(c < 0 ? -c : c) << (16 - FRAC_BITS);
      den = Q31_ONE + exp_neg_q31(mag);
      s   = udiv_u64((64'd1 << (31 + FRAC_BITS)) + (den >> 1), den);
      t[i] = (c < 0) ? ACT_W'(64'(1 << FRAC_BITS) - s) : ACT_W'(s);
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/mlp_backprop_train_step_top.sv =====
// One backpropagation training step of a 2-2-2 sigmoid MLP, Q4.12 fixed point.
// Uses mlpbp_pkg and mlp_backprop_train_step_top_macros.svh.
//
// Each request on s_axis carries two inputs and two targets. The block runs the
// forward pass, output and hidden deltas, then updates all eight weights, all
// on one shared 31x18 multiplier with a registered product and an accumulator,
// stepped by a small sequencer. A request passes through the forward/delta
// steps, the weight-update steps and a load of the output register before the
// result is offered on m_axis; s_tready is high only while idle, so a request
// is taken only once the last one has reached the output register. A result may
// wait in the output register while the next request is taken. The user must
// write the learning rate through cfg_we/cfg_wdata while idle; nothing enforces it.
`include "mlp_backprop_train_step_top_macros.svh"

module mlp_backprop_train_step_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mlpbp_pkg::LR_W-1:0] cfg_wdata,     // learning_rate
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,       // input_one, input_two, target_one, target_two
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [55:0]                m_tdata        // output_one, output_two, error_one, error_two
);
  import mlpbp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_UPD, ST_FIN} state_t;

  state_t                    state;
  logic [4:0]                step;
  logic [3:0]                k;
  logic                      ph;
  logic [LR_W-1:0]           lr;
  logic signed [NET_W-1:0]   wt [8];
  logic signed [NET_W-1:0]   x1, x2;
  logic [TGT_W-1:0]          t1, t2;
  logic [ACT_W-1:0]          n1, n2, y1, y2;
  logic signed [ERR_W-1:0]   d1, d2;
  logic signed [11:0]        sl;
  logic signed [17:0]        s1, s2;
  logic signed [NET_W-1:0]   hd1, hd2;
  logic signed [33:0]        acc;
  logic signed [47:0]        prod;
  logic signed [30:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [48:0]        mul_full;
  logic [ACT_W-1:0]          acc_sig;
  logic signed [47:0]        prod_r12;
  logic signed [13:0]        ty1, ty2;
  logic signed [NET_W-1:0]   upd_delta, upd_act;
  logic [2:0]                kw;
  logic signed [NET_W-1:0]   w_new;
  logic [ACT_W-1:0]          out_y1, out_y2;
  logic signed [ERR_W-1:0]   out_d1, out_d2;

  function automatic logic signed [47:0] rnd_sh(input logic signed [47:0] v, input int n);
    return (v + (48'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [47:0] sat_val(input logic signed [47:0] v,
                                                 input logic signed [47:0] lo,
                                                 input logic signed [47:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [47:0] sat16(input logic signed [47:0] v);
    return sat_val(v, -48'sd32768, 48'sd32767);
  endfunction

  function automatic logic signed [30:0] ext_u13(input logic [ACT_W-1:0] v);
    return 31'(signed'({1'b0, v}));
  endfunction

  // net from accumulator -> sigmoid table
  always_comb begin
    logic signed [NET_W-1:0] net;
    logic [NET_W-1:0]        biased;
    net     = NET_W'(sat16(rnd_sh(48'(acc), FRAC_BITS)));
    biased  = {~net[NET_W-1], net[NET_W-2:0]};
    acc_sig = SIG_TABLE[biased[NET_W-1 -: IDX_W]];
  end

  assign prod_r12  = rnd_sh(prod, FRAC_BITS);
  assign ty1       = signed'({1'b0, t1}) - signed'({1'b0, y1});
  assign ty2       = signed'({1'b0, t2}) - signed'({1'b0, y2});
  assign kw        = 3'(k - 4'd1);
  assign upd_delta = k[2] ? (k[0] ? hd2 : hd1) : NET_W'(k[0] ? d2 : d1);
  assign upd_act   = k[2] ? (k[1] ? x2 : x1) : signed'({3'b000, (k[1] ? n2 : n1)});
  assign w_new     = NET_W'(sat16(48'(wt[kw]) + rnd_sh(prod, 2 * FRAC_BITS)));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_RUN) begin
      case (step)
        5'd0:  begin mul_a = 31'(x1); mul_b = 18'(wt[4]); end
        5'd1:  begin mul_a = 31'(x2); mul_b = 18'(wt[6]); end
        5'd2:  begin mul_a = 31'(x1); mul_b = 18'(wt[5]); end
        5'd3:  begin mul_a = 31'(x2); mul_b = 18'(wt[7]); end
        5'd6:  begin mul_a = ext_u13(n1); mul_b = 18'(wt[0]); end
        5'd7:  begin mul_a = ext_u13(n2); mul_b = 18'(wt[2]); end
        5'd8:  begin mul_a = ext_u13(n1); mul_b = 18'(wt[1]); end
        5'd9:  begin mul_a = ext_u13(n2); mul_b = 18'(wt[3]); end
        5'd11: begin mul_a = ext_u13(y1); mul_b = 18'(ext_u13(ONE_Q - y1)); end
        5'd13: begin mul_a = 31'(sl); mul_b = 18'(ty1); end
        5'd14: begin mul_a = ext_u13(y2); mul_b = 18'(ext_u13(ONE_Q - y2)); end
        5'd16: begin mul_a = 31'(sl); mul_b = 18'(ty2); end
        5'd17: begin mul_a = 31'(wt[0]); mul_b = 18'(d1); end
        5'd18: begin mul_a = 31'(wt[1]); mul_b = 18'(d2); end
        5'd19: begin mul_a = 31'(wt[2]); mul_b = 18'(d1); end
        5'd20: begin mul_a = 31'(wt[3]); mul_b = 18'(d2); end
        5'd22: begin mul_a = ext_u13(n1); mul_b = 18'(ext_u13(ONE_Q - n1)); end
        5'd24: begin mul_a = 31'(sl); mul_b = s1; end
        5'd25: begin mul_a = ext_u13(n2); mul_b = 18'(ext_u13(ONE_Q - n2)); end
        5'd27: begin mul_a = 31'(sl); mul_b = s2; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == ST_UPD) begin
      if (!ph) begin
        mul_a = 31'(signed'({1'b0, lr}));
        mul_b = 18'(upd_delta);
      end else begin
        mul_a = prod[30:0];
        mul_b = 18'(upd_act);
      end
    end
  end

  assign mul_full = mul_a * mul_b;
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {6'b0, out_d2, out_d1, out_y2, out_y1};

  always_ff @(posedge clk) begin
    prod <= mul_full[47:0];
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      k        <= '0;
      ph       <= 1'b0;
      lr       <= LR_RESET;
      m_tvalid <= 1'b0;
      wt[0]    <= W_ONE;
      wt[1]    <= W_MONE;
      wt[2]    <= '0;
      wt[3]    <= W_ONE;
      wt[4]    <= W_MONE;
      wt[5]    <= '0;
      wt[6]    <= '0;
      wt[7]    <= W_ONE;
    end else begin
      if (cfg_we) lr <= cfg_wdata;
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x1    <= s_tdata[15:0];
            x2    <= s_tdata[31:16];
            t1    <= s_tdata[44:32];
            t2    <= s_tdata[57:45];
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          case (step)
            5'd1:  acc <= 34'(prod);
            5'd2:  acc <= acc + 34'(prod);
            5'd3:  begin n1 <= acc_sig; acc <= 34'(prod); end
            5'd4:  acc <= acc + 34'(prod);
            5'd5:  n2 <= acc_sig;
            5'd7:  acc <= 34'(prod);
            5'd8:  acc <= acc + 34'(prod);
            5'd9:  begin y1 <= acc_sig; acc <= 34'(prod); end
            5'd10: acc <= acc + 34'(prod);
            5'd11: y2 <= acc_sig;
            5'd12: sl <= 12'(prod_r12);
            5'd14: d1 <= ERR_W'(sat_val(prod_r12, -48'sd2048, 48'sd2047));
            5'd15: sl <= 12'(prod_r12);
            5'd17: d2 <= ERR_W'(sat_val(prod_r12, -48'sd2048, 48'sd2047));
            5'd18: acc <= 34'(prod);
            5'd19: acc <= acc + 34'(prod);
            5'd20: begin s1 <= 18'(rnd_sh(48'(acc), FRAC_BITS)); acc <= 34'(prod); end
            5'd21: acc <= acc + 34'(prod);
            5'd22: s2 <= 18'(rnd_sh(48'(acc), FRAC_BITS));
            5'd23: sl <= 12'(prod_r12);
            5'd25: hd1 <= NET_W'(sat16(prod_r12));
            5'd26: sl <= 12'(prod_r12);
            5'd28: begin
              hd2   <= NET_W'(sat16(prod_r12));
              k     <= '0;
              ph    <= 1'b0;
              state <= ST_UPD;
            end
            default: ;
          endcase
        end
        ST_UPD: begin
          ph <= ~ph;
          if (!ph) begin
            if (k != 4'd0) wt[kw] <= w_new;
            if (k == 4'd8) state <= ST_FIN;
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            out_y1   <= y1;
            out_y2   <= y2;
            out_d1   <= d1;
            out_d2   <= d2;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MLPBP_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == ST_RUN && step == 5'd0, "accept did not start the sequencer")
  `MLPBP_ASSERT_IMPL(a_upd_bound, state == ST_UPD, k <= 4'd8, "weight index ran past the last weight")
  `MLPBP_ASSERT_NEXT(a_upd_done, state == ST_UPD && k == 4'd8 && !ph, state == ST_FIN, "update pass did not finish")
  `MLPBP_ASSERT_NEXT(a_result_load, state == ST_FIN && (!m_tvalid || m_tready), m_tvalid && state == ST_IDLE, "result not loaded")

endmodule
